// ===== hw/rtl/ssvg_pkg.sv =====
// Shared constants, types and arithmetic helpers for the sphere strip vertex generator.
// Used by ssvg_sine and sphere_strip_vertex_generator_top; depends on nothing else.
`default_nettype none

package ssvg_pkg;

    // Upper bound on the detail level and the width of rounded angle steps.
    localparam int MAX_DETAIL = 256;
    localparam int ANGLE_BITS = 16;

    // Width of detail level, ring and segment numbers.
    localparam int DW = 9;
    localparam logic [DW-1:0] DETAIL_CAP = (MAX_DETAIL > 511) ? 9'd511 : 9'(MAX_DETAIL);

    // Divider: quotient width, remainder plus quotient register width, two steps per stage.
    localparam int QW         = 24;
    localparam int RW         = QW + DW;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = QW / DIV_STEPS;

    // Divider lanes.
    localparam int NUM_LANES = 4;
    localparam int LANE_LON  = 0;
    localparam int LANE_LAT  = 1;
    localparam int LANE_U    = 2;
    localparam int LANE_V    = 3;

    // Register stages inside one sine unit.
    localparam int SIN_LAT = 13;

    // Configuration register indexes.
    localparam logic [2:0] REG_RADIUS   = 3'd0;
    localparam logic [2:0] REG_CENTER_X = 3'd1;
    localparam logic [2:0] REG_CENTER_Y = 3'd2;
    localparam logic [2:0] REG_CENTER_Z = 3'd3;
    localparam logic [2:0] REG_DETAIL   = 3'd4;
    localparam logic [2:0] REG_START    = 3'd5;
    localparam logic [2:0] REG_TEX_EXP  = 3'd6;

    // Odd polynomial for sine on a quarter wave, Q30.
    localparam logic [30:0] C1 = 31'd1686629713;
    localparam logic [30:0] C3 = 31'd693598668;
    localparam logic [30:0] C5 = 31'd85569306;
    localparam logic [30:0] C7 = 31'd5026995;
    localparam logic [30:0] C9 = 31'd172263;
    localparam logic [30:0] HORNER_COEF [0:3] = '{C7, C5, C3, C1};

    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [19:0] TEX_U_MAX    = 20'hF_FFFF;

    typedef struct packed {
        logic pole;
        logic upper;
        logic closing;
    } pre_t;

    typedef struct packed {
        logic        pole;
        logic        upper;
        logic [19:0] tex_u;
        logic [16:0] tex_v;
    } side_t;

    // One restoring division step: remainder in the top DW bits, numerator bits
    // shift out at the top of the low QW bits while quotient bits shift in at the bottom.
    function automatic logic [RW-1:0] div_step(input logic [RW-1:0] rq,
                                               input logic [DW-1:0] d);
        logic [DW:0] t;
        logic [DW:0] r;
        logic        ge;
        t  = {rq[RW-1:QW], rq[QW-1]};
        ge = (t >= {1'b0, d});
        r  = ge ? (t - {1'b0, d}) : t;
        return {r[DW-1:0], rq[QW-2:0], ge};
    endfunction

    // Nonnegative Q60 to Q30, half up.
    function automatic logic [31:0] rnd30_u(input logic [61:0] v);
        logic [62:0] t;
        t = {1'b0, v} + (63'd1 << 29);
        return t[61:30];
    endfunction

    // Signed rounding, half away from zero.
    function automatic logic signed [33:0] rnds30_n(input logic signed [63:0] v);
        logic signed [64:0] t;
        t = 65'(v) + 65'sd536870912 - 65'(v[63]);
        return t[63:30];
    endfunction

    function automatic logic signed [26:0] rnds30_r(input logic signed [56:0] v);
        logic signed [57:0] t;
        t = 58'(v) + 58'sd536870912 - 58'(v[56]);
        return t[56:30];
    endfunction

    function automatic logic signed [17:0] rnds15(input logic signed [32:0] v);
        logic signed [33:0] t;
        t = 34'(v) + 34'sd16384 - 34'(v[32]);
        return t[32:15];
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
        logic signed [23:0] r;
        if (v > 28'sd8388607) begin
            r = 24'sh7F_FFFF;
        end else if (v < -28'sd8388608) begin
            r = 24'sh80_0000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -18'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ssvg_sine.sv =====
// Pipelined sine of a 32-bit turn phase, Q30 result, thirteen register stages.
// Depends on ssvg_pkg for the polynomial coefficients and rounding helpers.
`default_nettype none

module ssvg_sine (
    input  wire logic               aclk,
    input  wire logic               en,
    input  wire logic [31:0]        phase,
    output logic signed [31:0]      sin_out
);
    import ssvg_pkg::*;

    logic [30:0]        z_reg    [0:10];
    logic               neg_reg  [0:11];
    logic [61:0]        zz_reg;
    logic [30:0]        z2_reg   [2:8];
    logic [61:0]        prod_reg [0:3];
    logic [30:0]        s_reg    [0:3];
    logic [61:0]        zs_reg;
    logic signed [31:0] out_reg;

    logic [30:0] z_next;
    logic [31:0] z2_full;
    logic [30:0] mul_b     [0:3];
    logic [61:0] prod_next [0:3];
    logic [31:0] rp        [0:3];
    logic [30:0] s_next    [0:3];
    logic [31:0] mag;

    always_comb begin
        // Second and fourth quadrants mirror the first; the upper half negates.
        z_next   = phase[30] ? (31'h4000_0000 - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
        z2_full  = rnd30_u(zz_reg);
        mul_b[0] = C9;
        mul_b[1] = s_reg[0];
        mul_b[2] = s_reg[1];
        mul_b[3] = s_reg[2];
        for (int h = 0; h < 4; h++) begin
            prod_next[h] = z2_reg[2 + 2 * h] * mul_b[h];
            rp[h]        = rnd30_u(prod_reg[h]);
            s_next[h]    = HORNER_COEF[h] - rp[h][30:0];
        end
        mag = rnd30_u(zs_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            z_reg[0]   <= z_next;
            neg_reg[0] <= phase[31];
            for (int s = 1; s <= 10; s++) begin
                z_reg[s] <= z_reg[s - 1];
            end
            for (int s = 1; s <= 11; s++) begin
                neg_reg[s] <= neg_reg[s - 1];
            end
            zz_reg    <= z_reg[0] * z_reg[0];
            z2_reg[2] <= z2_full[30:0];
            for (int s = 3; s <= 8; s++) begin
                z2_reg[s] <= z2_reg[s - 1];
            end
            for (int h = 0; h < 4; h++) begin
                prod_reg[h] <= prod_next[h];
                s_reg[h]    <= s_next[h];
            end
            zs_reg  <= z_reg[10] * s_reg[3];
            out_reg <= neg_reg[11] ? -$signed(mag) : $signed(mag);
        end
    end

    assign sin_out = out_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/sphere_strip_vertex_generator_top.sv =====
// Top level of the sphere strip vertex generator: input split, divider, trig and vertex stages.
// Depends on ssvg_pkg and ssvg_sine.
//
//  channel | ports                                   | direction | handshake
//  input   | s_ring_index, s_segment_index           | in        | s_valid / s_ready
//  result  | m_pos_*, m_norm_*, m_tex_*, m_is_upper, | out       | m_valid / m_ready
//          | m_last                                  |           |
//  config  | cfg_addr, cfg_wr_data                   | in        | cfg_wr_en
//
// Each input item gives two vertex words, lower then upper, so a new item is taken only while
// the splitting input register is empty or holds an upper word, and the output is not stalled.
// A vertex word passes 29 pipeline stages plus the output register on its way from the split
// to the output (12 divider stages, 13 sine stages, 5 others).
// aresetn clears all valid bits and loads the register defaults; there is no clearing pass.
// When the output word is not taken, every stage holds; nothing is lost or repeated.
`default_nettype none

module sphere_strip_vertex_generator_top (
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               cfg_wr_en,
    input  wire logic [2:0]         cfg_addr,
    input  wire logic [23:0]        cfg_wr_data,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [8:0]         s_ring_index,
    input  wire logic [8:0]         s_segment_index,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [23:0]      m_pos_x,
    output logic signed [23:0]      m_pos_y,
    output logic signed [23:0]      m_pos_z,
    output logic signed [15:0]      m_norm_x,
    output logic signed [15:0]      m_norm_y,
    output logic signed [15:0]      m_norm_z,
    output logic [19:0]             m_tex_u,
    output logic [16:0]             m_tex_v,
    output logic                    m_is_upper,
    output logic                    m_last
);
    import ssvg_pkg::*;

    localparam int PIPE_LEN = 1 + DIV_STAGES + SIN_LAT + 3;

    // Configuration registers.
    logic [22:0]        radius_reg;
    logic signed [23:0] center_reg [0:2];
    logic [DW-1:0]      detail_reg;
    logic [15:0]        start_reg;
    logic [2:0]         tex_exp_reg;

    // Input register that splits an item into its lower and upper vertex words.
    logic          front_valid_reg;
    logic          front_upper_reg;
    logic [DW-1:0] front_k_reg;
    logic [DW-1:0] front_j_reg;

    logic              vld_reg [0:PIPE_LEN-1];
    logic              m_valid_reg;
    logic              adv;

    logic [DW-1:0] d_eff;
    logic [DW-1:0] k_next;
    logic [DW-1:0] j_next;
    logic [DW-1:0] kk;
    logic [RW-1:0] half;
    logic [RW-1:0] num_next [0:NUM_LANES-1];
    pre_t          pre_next;

    logic [RW-1:0] rq_reg  [0:DIV_STAGES][0:NUM_LANES-1];
    logic [RW-1:0] rq_next [0:DIV_STAGES-1][0:NUM_LANES-1];
    pre_t          pre_reg [0:DIV_STAGES];

    logic [QW-1:0] q_lon, q_lat, q_u, q_v;
    logic [31:0]   lon_ph, lat_ph;
    side_t         side_next;
    side_t         side_reg [0:SIN_LAT-1];

    logic signed [31:0] sin_lat, cos_lat, sin_lon, cos_lon;

    logic signed [63:0] x_prod_reg, z_prod_reg;
    logic signed [31:0] y_norm_reg;
    side_t              c1_side_reg;

    logic signed [32:0] n_reg [0:2];
    logic signed [32:0] n_next [0:2];
    side_t              c2_side_reg;

    logic signed [56:0] rad_prod_reg [0:2];
    logic signed [15:0] norm_reg [0:2];
    side_t              c3_side_reg;

    logic signed [23:0] pos_out_reg [0:2];
    logic signed [15:0] norm_out_reg [0:2];
    side_t              out_side_reg;

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg    <= 23'd4096;
            center_reg[0] <= '0;
            center_reg[1] <= '0;
            center_reg[2] <= '0;
            detail_reg    <= 9'd16;
            start_reg     <= 16'd49152;
            tex_exp_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_RADIUS:   radius_reg    <= cfg_wr_data[22:0];
                REG_CENTER_X: center_reg[0] <= cfg_wr_data;
                REG_CENTER_Y: center_reg[1] <= cfg_wr_data;
                REG_CENTER_Z: center_reg[2] <= cfg_wr_data;
                REG_DETAIL:   detail_reg    <= cfg_wr_data[DW-1:0];
                REG_START:    start_reg     <= cfg_wr_data[15:0];
                REG_TEX_EXP:  tex_exp_reg   <= cfg_wr_data[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (detail_reg == '0) begin
            d_eff = 9'd1;
        end else if (detail_reg > DETAIL_CAP) begin
            d_eff = DETAIL_CAP;
        end else begin
            d_eff = detail_reg;
        end
    end

    // ---------------- handshake and valid chain ----------------
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv && (!front_valid_reg || front_upper_reg);

    always_comb begin
        if (s_ring_index == '0) begin
            k_next = 9'd1;
        end else if (s_ring_index > d_eff) begin
            k_next = d_eff;
        end else begin
            k_next = s_ring_index;
        end
        j_next = (s_segment_index > d_eff) ? d_eff : s_segment_index;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
            front_upper_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
            for (int i = 0; i < PIPE_LEN; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            vld_reg[0] <= front_valid_reg;
            for (int i = 1; i < PIPE_LEN; i++) begin
                vld_reg[i] <= vld_reg[i - 1];
            end
            m_valid_reg <= vld_reg[PIPE_LEN - 1];
            if (s_valid && s_ready) begin
                front_valid_reg <= 1'b1;
                front_upper_reg <= 1'b0;
            end else if (front_valid_reg && front_upper_reg) begin
                front_valid_reg <= 1'b0;
            end else if (front_valid_reg) begin
                front_upper_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            front_k_reg <= k_next;
            front_j_reg <= j_next;
        end
    end

    // ---------------- numerators for the four divisions ----------------
    // Every quotient fits QW bits, so the numerator's top DW bits already
    // form a remainder below the divisor.
    always_comb begin
        kk       = front_upper_reg ? front_k_reg : (front_k_reg - 9'd1);
        half     = RW'(d_eff[DW-1:1]);
        pre_next = '{pole: (kk == '0), upper: front_upper_reg,
                     closing: (front_j_reg == d_eff)};
        num_next[LANE_LON] = pre_next.closing ? '0 :
                             ((RW'(front_j_reg) << ANGLE_BITS) + half);
        num_next[LANE_LAT] = (RW'(kk) << (ANGLE_BITS - 1)) + half;
        num_next[LANE_U]   = (RW'(d_eff - front_j_reg) << (5'd16 + 5'(tex_exp_reg))) + half;
        num_next[LANE_V]   = (RW'(kk) << 16) + half;
    end

    always_comb begin
        for (int i = 0; i < DIV_STAGES; i++) begin
            for (int l = 0; l < NUM_LANES; l++) begin
                rq_next[i][l] = rq_reg[i][l];
                for (int s = 0; s < DIV_STEPS; s++) begin
                    rq_next[i][l] = div_step(rq_next[i][l], d_eff);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pre_reg[0] <= pre_next;
            for (int l = 0; l < NUM_LANES; l++) begin
                rq_reg[0][l] <= num_next[l];
            end
            for (int i = 0; i < DIV_STAGES; i++) begin
                pre_reg[i + 1] <= pre_reg[i];
                for (int l = 0; l < NUM_LANES; l++) begin
                    rq_reg[i + 1][l] <= rq_next[i][l];
                end
            end
        end
    end

    // ---------------- phases and texture coordinates ----------------
    always_comb begin
        q_lon  = rq_reg[DIV_STAGES][LANE_LON][QW-1:0];
        q_lat  = rq_reg[DIV_STAGES][LANE_LAT][QW-1:0];
        q_u    = rq_reg[DIV_STAGES][LANE_U][QW-1:0];
        q_v    = rq_reg[DIV_STAGES][LANE_V][QW-1:0];
        // The closing segment wraps to longitude zero.
        lon_ph = pre_reg[DIV_STAGES].closing ? '0 :
                 (32'(q_lon[ANGLE_BITS-1:0]) << (32 - ANGLE_BITS));
        lat_ph = {start_reg, 16'h0000} + (32'(q_lat[ANGLE_BITS-1:0]) << (32 - ANGLE_BITS));
        side_next.pole  = pre_reg[DIV_STAGES].pole;
        side_next.upper = pre_reg[DIV_STAGES].upper;
        if (pre_reg[DIV_STAGES].closing) begin
            side_next.tex_u = '0;
        end else if (q_u > QW'(TEX_U_MAX)) begin
            side_next.tex_u = TEX_U_MAX;
        end else begin
            side_next.tex_u = q_u[19:0];
        end
        side_next.tex_v = q_v[16:0];
    end

    ssvg_sine u_sin_lat (.aclk(aclk), .en(adv), .phase(lat_ph), .sin_out(sin_lat));
    ssvg_sine u_cos_lat (.aclk(aclk), .en(adv), .phase(lat_ph + QUARTER_TURN),
                         .sin_out(cos_lat));
    ssvg_sine u_sin_lon (.aclk(aclk), .en(adv), .phase(lon_ph), .sin_out(sin_lon));
    ssvg_sine u_cos_lon (.aclk(aclk), .en(adv), .phase(lon_ph + QUARTER_TURN),
                         .sin_out(cos_lon));

    // ---------------- normal and position ----------------
    always_comb begin
        if (c1_side_reg.pole) begin
            n_next[0] = '0;
            n_next[1] = -33'sd1073741824;
            n_next[2] = '0;
        end else begin
            n_next[0] = 33'(rnds30_n(x_prod_reg));
            n_next[1] = 33'(y_norm_reg);
            n_next[2] = 33'(rnds30_n(z_prod_reg));
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0] <= side_next;
            for (int s = 1; s < SIN_LAT; s++) begin
                side_reg[s] <= side_reg[s - 1];
            end

            x_prod_reg  <= cos_lat * cos_lon;
            z_prod_reg  <= cos_lat * sin_lon;
            y_norm_reg  <= sin_lat;
            c1_side_reg <= side_reg[SIN_LAT - 1];

            for (int i = 0; i < 3; i++) begin
                n_reg[i] <= n_next[i];
            end
            c2_side_reg <= c1_side_reg;

            for (int i = 0; i < 3; i++) begin
                rad_prod_reg[i] <= $signed({1'b0, radius_reg}) * n_reg[i];
                norm_reg[i]     <= sat16(rnds15(n_reg[i]));
            end
            c3_side_reg <= c2_side_reg;

            for (int i = 0; i < 3; i++) begin
                pos_out_reg[i]  <= sat24(28'(center_reg[i]) + 28'(rnds30_r(rad_prod_reg[i])));
                norm_out_reg[i] <= norm_reg[i];
            end
            out_side_reg <= c3_side_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_pos_x    = pos_out_reg[0];
    assign m_pos_y    = pos_out_reg[1];
    assign m_pos_z    = pos_out_reg[2];
    assign m_norm_x   = norm_out_reg[0];
    assign m_norm_y   = norm_out_reg[1];
    assign m_norm_z   = norm_out_reg[2];
    assign m_tex_u    = out_side_reg.tex_u;
    assign m_tex_v    = out_side_reg.tex_v;
    assign m_is_upper = out_side_reg.upper;
    assign m_last     = out_side_reg.upper;

    // ---------------- checks ----------------
    // The upper vertex word travels right behind its lower one.
    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_is_upper) |=> (m_valid && m_is_upper))
        else $error("upper vertex word does not follow its lower word");

    a_split_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (front_valid_reg && !front_upper_reg))
        else $error("accepted item did not start with its lower vertex word");

    a_c1_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[0] && adv) |=> vld_reg[1])
        else $error("valid bit lost entering the divider");

endmodule

`default_nettype wire
